// ----- design/hcnt_pkg.sv -----
`default_nettype none

package hcnt_pkg;

	// field widths fixed by the interface
	localparam int PORT_ADDR_W = 16;
	localparam int HOPS_W      = 8;
	localparam int AGE_W       = 16;
	localparam int CFG_IDX_W   = 1;

	// defaults for the top-level parameters
	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int ADDR_BITS_DEF     = 16;

	localparam logic [HOPS_W-1:0] HOPS_UNKNOWN  = 8'd255;
	localparam logic [AGE_W-1:0]  TIMEOUT_RESET = 16'd60;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NODE_IS_SINK  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

	typedef enum logic [1:0] {
		MODE_ANNOUNCE = 2'd0,
		MODE_FORWARD  = 2'd1,
		MODE_TICK     = 2'd2,
		MODE_REPORT   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_FINISH
	} state_t;

	// sequencer to datapath
	typedef struct packed {
		logic rd_en;
		logic finish;
		logic busy;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- design/hcnt_ram.sv -----
`default_nettype none

module hcnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/hcnt_ctrl.sv -----
`default_nettype none

module hcnt_ctrl
	import hcnt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output ctrl_t                 ctrl,
	output logic      [IDX_W-1:0] rd_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.rd_en  = 1'b0;
		ctrl.finish = 1'b0;
		ctrl.busy   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				ctrl.busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				ctrl.rd_en = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_idx = idx_q;

endmodule

`default_nettype wire

// ----- design/hop_count_neighbor_table_unit.sv -----
`default_nettype none
// a word accepted on start is scanned through every entry, then gives its result on done
// a new word is taken only once the block is idle again (busy low), since the
//   entry memory is scanned sequentially through its single read port
// done is a one-cycle strobe; the receiver cannot stall, so results are not buffered
// reset: arst_n clears the valid bits (table empty), the sequencer and the config
//   registers (not sink, timeout 60); entry memory contents are left as they are

module hop_count_neighbor_table_unit
	import hcnt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// command side
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             mode,
	input  wire logic [PORT_ADDR_W-1:0] neighbor_addr,
	input  wire logic [HOPS_W-1:0]      hop_count,
	// result side
	output logic                        done,
	output logic                        announce,
	output logic      [HOPS_W-1:0]      announce_hops,
	output logic                        forward_found,
	output logic      [PORT_ADDR_W-1:0] next_hop_addr,
	output logic                        table_full,
	// configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [AGE_W-1:0]       cfg_data
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	// stored address: the port address reduced to ADDR_BITS
	localparam int KEY_W  = (ADDR_BITS < PORT_ADDR_W) ? ADDR_BITS : PORT_ADDR_W;
	// memory word: {address, hops, age left}
	localparam int WORD_W = KEY_W + HOPS_W + AGE_W;

	ctrl_t            ctrl;
	logic [IDX_W-1:0] rd_idx;

	// config registers
	logic             sink_q;
	logic [AGE_W-1:0] timeout_q;

	// valid bits live in flops so reset empties the table at once
	logic [TABLE_ENTRIES-1:0] valid_q;

	// captured command word
	mode_t             mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [HOPS_W-1:0] hin_q;

	// read pipeline tag, lines up with the registered memory read data
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// scan accumulators
	logic [HOPS_W-1:0] best_q;
	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [HOPS_W-1:0] match_hops_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [HOPS_W-1:0] fwd_best_q;
	logic              fwd_found_q;
	logic [KEY_W-1:0]  fwd_addr_q;

	// memory ports
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	logic              e_valid;
	logic [KEY_W-1:0]  e_addr;
	logic [HOPS_W-1:0] e_hops;
	logic [AGE_W-1:0]  e_age;

	logic              accept;
	logic              tick_wr;
	logic              tick_evict;
	logic              ins_wr;
	logic [HOPS_W-1:0] cur_best_p1;

	logic              res_announce;
	logic [HOPS_W-1:0] res_announce_hops;
	logic              res_forward_found;
	logic [KEY_W-1:0]  res_next_hop;
	logic              res_table_full;

	hcnt_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.ctrl  (ctrl),
		.rd_idx(rd_idx)
	);

	hcnt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (ctrl.rd_en),
		.raddr(rd_idx),
		.rdata(mem_rdata)
	);

	assign busy      = ctrl.busy;
	assign cfg_ready = ~ctrl.busy;
	assign accept    = start & ~ctrl.busy;

	// fields of the entry read last cycle
	assign e_valid = valid_q[rd_idx_s1];
	assign e_age   = mem_rdata[AGE_W-1:0];
	assign e_hops  = mem_rdata[AGE_W +: HOPS_W];
	assign e_addr  = mem_rdata[AGE_W+HOPS_W +: KEY_W];

	// best hops plus one before this word touched the table, saturating at unknown
	assign cur_best_p1 = (best_q == HOPS_UNKNOWN) ? HOPS_UNKNOWN : best_q + 1'b1;

	// tick: read-modify-write of each entry, written back in the cycle after its read
	assign tick_wr    = rd_vld_s1 && (mode_q == MODE_TICK) && e_valid && (e_age > AGE_W'(1));
	assign tick_evict = rd_vld_s1 && (mode_q == MODE_TICK) && e_valid && (e_age <= AGE_W'(1));

	// announcement: refresh the matching entry or fill the lowest free slot after the scan
	assign ins_wr = ctrl.finish && (mode_q == MODE_ANNOUNCE) && !sink_q &&
		(match_found_q || free_found_q);

	always_comb begin
		mem_we    = tick_wr | ins_wr;
		mem_waddr = rd_idx_s1;
		mem_wdata = {e_addr, e_hops, e_age - 1'b1};
		if (!tick_wr) begin
			if (match_found_q) begin
				mem_waddr = match_idx_q;
				mem_wdata = {key_q, (hin_q == HOPS_UNKNOWN) ? match_hops_q : hin_q, timeout_q};
			end else begin
				mem_waddr = free_idx_q;
				mem_wdata = {key_q, hin_q, timeout_q};
			end
		end
	end

	// result of the finished scan
	always_comb begin
		res_announce      = 1'b0;
		res_announce_hops = '0;
		res_forward_found = 1'b0;
		res_next_hop      = '0;
		res_table_full    = 1'b0;
		case (mode_q)
			MODE_ANNOUNCE: begin
				if (!sink_q) begin
					res_table_full = !match_found_q && !free_found_q;
					if (!res_table_full && (hin_q != HOPS_UNKNOWN) &&
						((cur_best_p1 == HOPS_UNKNOWN) || (hin_q < cur_best_p1))) begin
						res_announce      = 1'b1;
						res_announce_hops = hin_q + 1'b1;
					end
				end
			end
			MODE_FORWARD: begin
				res_forward_found = fwd_found_q;
				res_next_hop      = fwd_found_q ? fwd_addr_q : '0;
			end
			MODE_REPORT: begin
				res_announce      = 1'b1;
				res_announce_hops = sink_q ? '0 : cur_best_p1;
			end
			default: begin
				// tick gives an empty result
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_q    <= 1'b0;
			timeout_q <= TIMEOUT_RESET;
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NODE_IS_SINK:  sink_q    <= cfg_data[0];
					REG_TIMEOUT_TICKS: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (tick_evict) begin
				valid_q[rd_idx_s1] <= 1'b0;
			end
			if (ins_wr && !match_found_q) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			rd_vld_s1 <= ctrl.rd_en;
			done      <= ctrl.finish;
		end
	end

	// datapath, no reset needed: command and flags load on accept, the rest before use
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
		if (accept) begin
			mode_q        <= mode_t'(mode);
			key_q         <= neighbor_addr[KEY_W-1:0];
			hin_q         <= hop_count;
			best_q        <= HOPS_UNKNOWN;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			fwd_best_q    <= HOPS_UNKNOWN;
			fwd_found_q   <= 1'b0;
		end else if (rd_vld_s1) begin
			if (e_valid && (e_hops < best_q)) begin
				best_q <= e_hops;
			end
			// first valid entry with this address
			if (e_valid && !match_found_q && (e_addr == key_q)) begin
				match_found_q <= 1'b1;
				match_idx_q   <= rd_idx_s1;
				match_hops_q  <= e_hops;
			end
			// lowest free slot
			if (!e_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
			// strict compare keeps the lowest slot on ties
			if (e_valid && (e_addr != key_q) && (e_hops < fwd_best_q)) begin
				fwd_best_q  <= e_hops;
				fwd_found_q <= 1'b1;
				fwd_addr_q  <= e_addr;
			end
		end
		if (ctrl.finish) begin
			announce      <= res_announce;
			announce_hops <= res_announce_hops;
			forward_found <= res_forward_found;
			next_hop_addr <= PORT_ADDR_W'(res_next_hop);
			table_full    <= res_table_full;
		end
	end

endmodule

`default_nettype wire

// ----- design/hcnt_checker.sv -----
`default_nettype none

module hcnt_checker
	import hcnt_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic                   done,
	input wire logic                   announce,
	input wire logic [HOPS_W-1:0]      announce_hops,
	input wire logic                   forward_found,
	input wire logic                   table_full
);

	// a word only starts work when it was accepted
	assert property (@(posedge clk) disable iff (!arst_n) $rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// the result strobe comes once the word is finished
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while still busy");

	// a result carries at most one kind of outcome
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(announce && forward_found) && !(announce && table_full) &&
			!(forward_found && table_full))
		else $error("result flags overlap");

	// silent results carry no hop count
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !announce) |-> (announce_hops == '0))
		else $error("hop count without announce");

endmodule

bind hop_count_neighbor_table_unit hcnt_checker u_hcnt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.announce     (announce),
	.announce_hops(announce_hops),
	.forward_found(forward_found),
	.table_full   (table_full)
);

`default_nettype wire

// ----- tb/hop_count_neighbor_table_unit_test.sv -----
`default_nettype none

module hop_count_neighbor_table_unit_test;
	import hcnt_pkg::*;

	localparam int TABLE_SLOTS = TABLE_ENTRIES_DEF;
	// drain limit: eight words of a full table scan each, plus a margin
	localparam int DRAIN_LIMIT = 8 * (TABLE_SLOTS + 3) + 50;
	localparam int POOL_SIZE   = 22;

	// one result word as it leaves the block
	typedef struct packed {
		logic                   announce;
		logic [HOPS_W-1:0]      announce_hops;
		logic                   forward_found;
		logic [PORT_ADDR_W-1:0] next_hop_addr;
		logic                   table_full;
	} route_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	mode_t                  cmd_mode = MODE_ANNOUNCE;
	logic [PORT_ADDR_W-1:0] neighbor_addr = '0;
	logic [HOPS_W-1:0]      hop_count = '0;
	logic                   done;
	logic                   announce;
	logic [HOPS_W-1:0]      announce_hops;
	logic                   forward_found;
	logic [PORT_ADDR_W-1:0] next_hop_addr;
	logic                   table_full;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [AGE_W-1:0]       cfg_data = '0;

	hop_count_neighbor_table_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (cmd_mode),
		.neighbor_addr(neighbor_addr),
		.hop_count    (hop_count),
		.done         (done),
		.announce     (announce),
		.announce_hops(announce_hops),
		.forward_found(forward_found),
		.next_hop_addr(next_hop_addr),
		.table_full   (table_full),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the neighbor table and the node settings
	logic                   nbr_live [TABLE_SLOTS];
	logic [PORT_ADDR_W-1:0] nbr_addr [TABLE_SLOTS];
	logic [HOPS_W-1:0]      nbr_hops [TABLE_SLOTS];
	logic [AGE_W-1:0]       nbr_ttl  [TABLE_SLOTS];
	logic                   sink_flag = 1'b0;
	logic [AGE_W-1:0]       ttl_reload = TIMEOUT_RESET;

	route_result_t route_due [$];
	int            mismatches = 0;
	bit            idle_enabled = 1'b1;

	initial begin
		foreach (nbr_live[k])
			nbr_live[k] = 1'b0;
	end

	// hops this node would advertise: best neighbor plus one, saturating at unknown
	function automatic logic [HOPS_W-1:0] advertised_hops();
		logic [HOPS_W-1:0] best;
		best = HOPS_UNKNOWN;
		for (int k = 0; k < TABLE_SLOTS; k++)
			if (nbr_live[k] && nbr_hops[k] < best)
				best = nbr_hops[k];
		return (best == HOPS_UNKNOWN) ? HOPS_UNKNOWN : best + 8'd1;
	endfunction

	// applies one command word to the shadow table and returns the result word
	function automatic route_result_t route_update(input mode_t m,
			input logic [PORT_ADDR_W-1:0] a, input logic [HOPS_W-1:0] h);
		route_result_t     r;
		logic [HOPS_W-1:0] cur;
		logic [HOPS_W-1:0] best;
		int                hit;
		int                free_slot;
		bit                stored;
		r = '0;
		case (m)
			MODE_ANNOUNCE: begin
				// the sink ignores announcements and answers with all zero
				if (!sink_flag) begin
					cur = advertised_hops();
					hit = -1;
					free_slot = -1;
					for (int k = 0; k < TABLE_SLOTS; k++) begin
						if (nbr_live[k]) begin
							if (hit < 0 && nbr_addr[k] == a)
								hit = k;
						end else if (free_slot < 0) begin
							free_slot = k;
						end
					end
					stored = 1'b1;
					if (hit >= 0) begin
						// refresh; an unknown count leaves the old hops in place
						nbr_ttl[hit] = ttl_reload;
						if (h != HOPS_UNKNOWN)
							nbr_hops[hit] = h;
					end else if (free_slot >= 0) begin
						nbr_live[free_slot] = 1'b1;
						nbr_addr[free_slot] = a;
						nbr_hops[free_slot] = h;
						nbr_ttl[free_slot]  = ttl_reload;
					end else begin
						r.table_full = 1'b1;
						stored = 1'b0;
					end
					if (stored && h != HOPS_UNKNOWN && (cur == HOPS_UNKNOWN || h < cur)) begin
						r.announce      = 1'b1;
						r.announce_hops = h + 8'd1;
					end
				end
			end
			MODE_FORWARD: begin
				// strict less-than keeps the lowest slot on ties and skips unknown hops
				best = HOPS_UNKNOWN;
				for (int k = 0; k < TABLE_SLOTS; k++) begin
					if (nbr_live[k] && nbr_addr[k] != a && nbr_hops[k] < best) begin
						best            = nbr_hops[k];
						r.forward_found = 1'b1;
						r.next_hop_addr = nbr_addr[k];
					end
				end
			end
			MODE_TICK: begin
				// a reload of zero acts like one: gone at the next tick
				for (int k = 0; k < TABLE_SLOTS; k++) begin
					if (nbr_live[k]) begin
						if (nbr_ttl[k] <= 16'd1) begin
							nbr_live[k] = 1'b0;
							nbr_ttl[k]  = '0;
						end else begin
							nbr_ttl[k] = nbr_ttl[k] - 16'd1;
						end
					end
				end
			end
			default: begin
				r.announce      = 1'b1;
				r.announce_hops = sink_flag ? 8'd0 : advertised_hops();
			end
		endcase
		return r;
	endfunction

	// every done strobe carries one word; compare it with the oldest prediction
	always @(posedge clk) begin : check_results
		route_result_t want;
		if (arst_n && done) begin
			if (route_due.size() == 0) begin
				$error("result word with no command pending");
				mismatches++;
			end else begin
				want = route_due.pop_front();
				if (announce !== want.announce) begin
					$error("announce expected %0d got %0d", want.announce, announce);
					mismatches++;
				end
				if (announce_hops !== want.announce_hops) begin
					$error("announce_hops expected %0d got %0d",
						want.announce_hops, announce_hops);
					mismatches++;
				end
				if (forward_found !== want.forward_found) begin
					$error("forward_found expected %0d got %0d",
						want.forward_found, forward_found);
					mismatches++;
				end
				if (next_hop_addr !== want.next_hop_addr) begin
					$error("next_hop_addr expected %h got %h",
						want.next_hop_addr, next_hop_addr);
					mismatches++;
				end
				if (table_full !== want.table_full) begin
					$error("table_full expected %0d got %0d", want.table_full, table_full);
					mismatches++;
				end
			end
		end
	end

	// one command word: optional sender gap, then hold start until busy is low at an edge
	task automatic send_word(input mode_t m, input logic [PORT_ADDR_W-1:0] a,
			input logic [HOPS_W-1:0] h);
		int gap;
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			// sometimes let the block go idle first so the gap lands in a new phase
			if ($urandom_range(0, 1) == 1) begin
				do @(posedge clk); while (busy);
			end
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		cmd_mode      <= m;
		neighbor_addr <= a;
		hop_count     <= h;
		do @(posedge clk); while (busy);
		route_due.push_back(route_update(m, a, h));
	endtask

	// drop start and wait for every predicted word to come back
	task automatic wait_drained();
		int guard;
		guard = 0;
		start <= 1'b0;
		@(posedge clk);
		while (route_due.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (route_due.size() != 0) begin
			$error("%0d result words never arrived", route_due.size());
			mismatches++;
			route_due.delete();
		end
	endtask

	// writes both registers back to back; valid stays up between the two words
	task automatic program_node(input logic sink, input logic [AGE_W-1:0] ttl);
		cfg_valid <= 1'b1;
		cfg_index <= REG_NODE_IS_SINK;
		// upper data bits are don't-care for the sink flag
		cfg_data  <= {15'($urandom), sink};
		do @(posedge clk); while (!cfg_ready);
		sink_flag = sink;
		cfg_index <= REG_TIMEOUT_TICKS;
		cfg_data  <= ttl;
		do @(posedge clk); while (!cfg_ready);
		ttl_reload = ttl;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// empty table: report stays unknown, forward finds nothing
	task automatic test_empty_table();
		send_word(MODE_REPORT, 16'h0000, 8'd0);
		send_word(MODE_FORWARD, 16'hFFFF, 8'hFF);
	endtask

	// insert with a new best, insert worse, insert unknown, refresh with unknown, then report
	task automatic test_announce_paths();
		send_word(MODE_ANNOUNCE, 16'h0000, 8'd0);
		send_word(MODE_ANNOUNCE, 16'hFFFF, 8'd254);
		send_word(MODE_ANNOUNCE, 16'h1234, HOPS_UNKNOWN);
		send_word(MODE_ANNOUNCE, 16'h0000, HOPS_UNKNOWN);
		send_word(MODE_REPORT, 16'h5A5A, 8'hA5);
	endtask

	// previous hop excluded, unknown-hops neighbor never picked
	task automatic test_forward_choice();
		send_word(MODE_FORWARD, 16'h0000, 8'd0);
	endtask

	// fill every remaining slot, then one more new neighbor overflows
	task automatic test_table_overflow();
		for (int k = 0; k < TABLE_SLOTS - 3; k++)
			send_word(MODE_ANNOUNCE, 16'h0001 << k, 8'($urandom_range(1, 254)));
		send_word(MODE_ANNOUNCE, 16'h8000, 8'd7);
	endtask

	// reload of zero: refreshed neighbor goes at the very next tick
	task automatic test_zero_timeout();
		wait_drained();
		program_node(1'b0, 16'd0);
		send_word(MODE_ANNOUNCE, 16'hFFFF, 8'd3);
		send_word(MODE_TICK, 16'h0000, 8'd0);
	endtask

	// sink ignores announcements and reports zero hops
	task automatic test_sink_node();
		wait_drained();
		program_node(1'b1, TIMEOUT_RESET);
		send_word(MODE_ANNOUNCE, 16'h4321, 8'd0);
		send_word(MODE_REPORT, 16'hFFFF, 8'hFF);
	endtask

	// random traffic over a small address pool so the table fills, ages and churns
	task automatic test_random_traffic(input logic sink, input logic [AGE_W-1:0] ttl,
			input int words);
		logic [PORT_ADDR_W-1:0] pool [POOL_SIZE];
		logic [PORT_ADDR_W-1:0] a;
		logic [HOPS_W-1:0]      h;
		mode_t                  m;
		int                     pick;
		wait_drained();
		program_node(sink, ttl);
		foreach (pool[i])
			pool[i] = 16'($urandom);
		for (int n = 0; n < words; n++) begin
			pick = $urandom_range(0, 19);
			if (pick < 10)
				m = MODE_ANNOUNCE;
			else if (pick < 14)
				m = MODE_FORWARD;
			else if (pick < 17)
				m = MODE_TICK;
			else
				m = MODE_REPORT;
			// mostly known neighbors, now and then a stranger
			a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 9);
			if (pick == 0)
				h = HOPS_UNKNOWN;
			else if (pick == 1)
				h = 8'($urandom);
			else
				h = 8'($urandom_range(0, 12));
			send_word(m, a, h);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_announce_paths();
		test_forward_choice();
		test_table_overflow();
		test_zero_timeout();
		test_sink_node();

		// settings sweep: short lives, shortest life, longest life, sink, moderate
		test_random_traffic(1'b0, 16'd4, 300);
		test_random_traffic(1'b0, 16'd1, 200);
		test_random_traffic(1'b0, 16'hFFFF, 300);
		test_random_traffic(1'b1, 16'd10, 150);
		test_random_traffic(1'b0, 16'd12, 300);
		// back-to-back words to finish
		idle_enabled = 1'b0;
		test_random_traffic(1'b0, 16'd6, 300);

		wait_drained();
		repeat (TABLE_SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("hop_count_neighbor_table_unit verification clean");
		else
			$display("hop_count_neighbor_table_unit verification failed");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("hop_count_neighbor_table_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
